@@ rtl/integer_to_decimal_ascii_defines.svh @@
// assertion macros for the integer to decimal ascii converter
// no dependencies; included by i2da_ctrl, the only module that carries assertions
`ifndef INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH
`define INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define I2DA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("i2da check failed");
// expression must never be true outside reset
`define I2DA_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("i2da forbidden condition");
`else
`define I2DA_ASSERT(lbl, clk, rstn, prop)
`define I2DA_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

@@ rtl/i2da_pkg.sv @@
// shared types and constants of the integer to decimal ascii converter
// no dependencies
`timescale 1ns / 1ps

package i2da_pkg;

  localparam int MagW      = 128;
  localparam int HalfW     = 64;
  localparam int DigitW    = 4;
  localparam int NumDigits = 40;
  localparam int BcdW      = NumDigits * DigitW;
  localparam int DigIdxW   = $clog2(NumDigits);
  localparam int BitCntW   = $clog2(MagW);

  localparam logic [7:0] CharZero    = 8'd48;
  localparam logic [7:0] CharMinus   = 8'd45;
  localparam logic [7:0] CharNewline = 8'd10;

  // input modes; the unused code falls back to unsigned 128-bit
  typedef enum logic [1:0] {
    OP_S64  = 2'd0,
    OP_S128 = 2'd1,
    OP_U128 = 2'd2
  } opcode_e;

  // which character the output register takes
  typedef enum logic [1:0] {
    CH_SEL_DIGIT = 2'd0,
    CH_SEL_MINUS = 2'd1,
    CH_SEL_NL    = 2'd2
  } char_sel_e;

  typedef struct packed {
    logic      load;
    logic      shift;
    logic      put;
    char_sel_e char_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic neg;
    logic top_zero;
  } dp_sts_t;

endpackage

@@ rtl/integer_to_decimal_ascii.sv @@
// integer to decimal ascii: one word in, its decimal text out one byte a word
// first byte: the load, one shift per magnitude bit, then the put of the first character
// output: n bytes per word (2..41), produced after the bit-serial loop
// one byte per cycle on output while not stalled; next word accepted after the newline is queued
// reset: controller to idle, no output word valid, conversion counters cleared
// depends on i2da_pkg, i2da_ctrl, i2da_dp
`timescale 1ns / 1ps

module integer_to_decimal_ascii
  import i2da_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input word channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] value_low_i,
  input  logic [63:0] value_high_i,
  // output byte channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  char_byte_o,
  output logic        last_o
);

  // command and status between the sequencer and the datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: idle, bit-serial conversion, sign, digits msd first, newline
  i2da_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // magnitude and bcd shift registers plus the output byte register
  i2da_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (opcode_i),
    .value_low_i  (value_low_i),
    .value_high_i (value_high_i),
    .char_byte_o  (char_byte_o),
    .last_o       (last_o)
  );

endmodule

@@ rtl/i2da_dp.sv @@
// datapath: magnitude register, double-dabble bcd shifter, output word register
// depends on i2da_pkg
`timescale 1ns / 1ps

module i2da_dp
  import i2da_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dp_cmd_t      cmd_i,
  output dp_sts_t      sts_o,
  input  logic [1:0]   opcode_i,
  input  logic [63:0]  value_low_i,
  input  logic [63:0]  value_high_i,
  output logic [7:0]   char_byte_o,
  output logic         last_o
);

  localparam logic [DigIdxW-1:0] TopMax = DigIdxW'(NumDigits - 1);

  logic [MagW-1:0]    mag_q, mag_d, mag_load;
  logic [BcdW-1:0]    bcd_q, bcd_d, bcd_adj, bcd_shift;
  logic [DigIdxW-1:0] top_q, top_d, top_nx;
  logic [BitCntW-1:0] bitcnt_q, bitcnt_d;
  logic               neg_q, neg_d, neg_load;
  logic [7:0]         char_q, char_d;
  logic               last_q, last_d;
  logic               top_inc;
  logic [DigitW-1:0]  top_digit;

  // sign and magnitude of the incoming word
  always_comb begin
    unique case (opcode_e'(opcode_i))
      OP_S64: begin
        neg_load = value_low_i[HalfW-1];
        mag_load = {{HalfW{1'b0}}, (neg_load ? (~value_low_i + 64'd1) : value_low_i)};
      end
      OP_S128: begin
        neg_load = value_high_i[HalfW-1];
        mag_load = neg_load ? (~{value_high_i, value_low_i} + 128'd1)
                            : {value_high_i, value_low_i};
      end
      default: begin
        neg_load = 1'b0;
        mag_load = {value_high_i, value_low_i};
      end
    endcase
  end

  // add-3 correction on every digit of 5 or more, then shift in the next magnitude bit
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*DigitW +: DigitW] >= 4'd5) begin
        bcd_adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW] + 4'd3;
      end else begin
        bcd_adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW];
      end
    end
  end

  assign bcd_shift = {bcd_adj[BcdW-2:0], mag_q[MagW-1]};
  assign top_nx    = top_q + 1'b1;
  // the digit count grows by at most one per shift
  assign top_inc   = (top_q != TopMax) && (bcd_shift[{top_nx, 2'b00} +: DigitW] != '0);
  assign top_digit = bcd_q[{top_q, 2'b00} +: DigitW];

  always_comb begin
    mag_d    = mag_q;
    bcd_d    = bcd_q;
    top_d    = top_q;
    bitcnt_d = bitcnt_q;
    neg_d    = neg_q;
    char_d   = char_q;
    last_d   = last_q;
    if (cmd_i.load) begin
      mag_d    = mag_load;
      bcd_d    = '0;
      top_d    = '0;
      bitcnt_d = '0;
      neg_d    = neg_load;
    end else if (cmd_i.shift) begin
      mag_d    = {mag_q[MagW-2:0], 1'b0};
      bcd_d    = bcd_shift;
      top_d    = top_inc ? top_nx : top_q;
      bitcnt_d = bitcnt_q + 1'b1;
    end
    if (cmd_i.put) begin
      unique case (cmd_i.char_sel)
        CH_SEL_MINUS: begin
          char_d = CharMinus;
          last_d = 1'b0;
        end
        CH_SEL_NL: begin
          char_d = CharNewline;
          last_d = 1'b1;
        end
        default: begin
          char_d = CharZero + {4'b0000, top_digit};
          last_d = 1'b0;
          if (top_q != '0) begin
            top_d = top_q - 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= '0;
      bitcnt_q <= '0;
      neg_q    <= 1'b0;
    end else begin
      top_q    <= top_d;
      bitcnt_q <= bitcnt_d;
      neg_q    <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign sts_o.conv_done = (bitcnt_q == '1);
  assign sts_o.neg       = neg_q;
  assign sts_o.top_zero  = (top_q == '0);
  assign char_byte_o     = char_q;
  assign last_o          = last_q;

endmodule

@@ rtl/i2da_ctrl.sv @@
// controller: sequences load, conversion and character output, owns handshakes
// depends on i2da_pkg and integer_to_decimal_ascii_defines.svh
`timescale 1ns / 1ps
`include "integer_to_decimal_ascii_defines.svh"

module i2da_ctrl
  import i2da_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_SIGN  = 5'b00100,
    S_DIGIT = 5'b01000,
    S_NL    = 5'b10000
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free;
  dp_cmd_t cmd;

  // output register can take a new word this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && out_stall_i;
    cmd          = '0;
    cmd.char_sel = CH_SEL_DIGIT;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        if (sts_i.conv_done) begin
          state_d = sts_i.neg ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          cmd.put      = 1'b1;
          cmd.char_sel = CH_SEL_MINUS;
          out_valid_d  = 1'b1;
          state_d      = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          cmd.put     = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.top_zero) begin
            state_d = S_NL;
          end
        end
      end
      S_NL: begin
        if (out_free) begin
          cmd.put      = 1'b1;
          cmd.char_sel = CH_SEL_NL;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `I2DA_ASSERT_NEVER(a_put_over_held_word, clk_i, rst_ni, cmd.put && out_valid_q && out_stall_i)
  `I2DA_ASSERT(a_load_starts_conv, clk_i, rst_ni, cmd.load |=> (state_q == S_CONV))
  `I2DA_ASSERT(a_conv_exit, clk_i, rst_ni, (state_q == S_CONV && sts_i.conv_done) |=> (state_q == S_SIGN || state_q == S_DIGIT))
  `I2DA_ASSERT(a_newline_ends_run, clk_i, rst_ni, (cmd.put && cmd.char_sel == CH_SEL_NL) |=> (state_q == S_IDLE && out_valid_q))

endmodule
